// ===== rtl/parabolic_sine_cosine_defines.svh =====
// Assertion macros used by the parabolic sine/cosine top level.
`ifndef PARABOLIC_SINE_COSINE_DEFINES_SVH
`define PARABOLIC_SINE_COSINE_DEFINES_SVH

// Check on every clock edge outside reset.
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/psc_pkg.sv =====
// Constants and types for the parabolic sine/cosine pipeline.
`timescale 1ns / 1ps

package psc_pkg;

  // Default parameter values
  localparam int AngleWidthDef = 20;
  localparam int OutFracDef    = 14;

  // Fixed field and internal formats
  localparam int ValueW  = 16;
  localparam int IntFrac = 14;

  // Angle constants, Q12 radians; 2*pi splits as 3217 * 8
  localparam int PiQ12      = 12868;
  localparam int TwoPiQ12   = 25736;
  localparam int HalfPiQ12  = 6434;
  localparam int TwoPiOdd   = 3217;
  localparam int TwoPiShift = 3;

  // Q14 coefficients: 4/pi, 4/pi^2 and the 0.225 refinement
  localparam int KLin = 20861;
  localparam int KSqr = 6640;
  localparam int KFix = 3686;

  // Internal widths of the polynomial datapath
  localparam int MagW = 14;
  localparam int XW   = 17;
  localparam int T1W  = 18;
  localparam int SW   = 19;
  localparam int YW   = 19;
  localparam int DW   = 19;
  localparam int RW   = 20;

  // Pipeline depth of each section
  localparam int RedStages = 4;
  localparam int ParStages = 4;
  localparam int NumStages = RedStages + ParStages;

  // Per-stage load enables handed to each section
  typedef logic [RedStages-1:0] red_en_t;
  typedef logic [ParStages-1:0] par_en_t;

  typedef struct packed {
    red_en_t red;
    par_en_t par;
  } stage_en_t;

endpackage

// ===== rtl/psc_reduce.sv =====
// Angle offset and range reduction into [-pi, pi], four register stages.
`timescale 1ns / 1ps

module psc_reduce #(
  parameter int ANGLE_WIDTH = psc_pkg::AngleWidthDef
) (
  input  logic                              clk_i,
  input  psc_pkg::red_en_t                  en_i,
  input  logic                              req_type_i,
  input  logic signed [ANGLE_WIDTH-1:0]     angle_i,
  output logic signed [psc_pkg::XW-1:0]     x_o
);

  localparam int SumW = ANGLE_WIDTH + 1;
  localparam int MW   = ANGLE_WIDTH;
  localparam int NW   = ANGLE_WIDTH - psc_pkg::TwoPiShift;
  localparam int KW   = NW - 11;
  // Reciprocal of 3217 scaled by 2^NW; the estimate is low by at most one
  localparam logic [KW-1:0] Recip = KW'((longint'(1) << NW) / psc_pkg::TwoPiOdd);

  // Stage 1: add the cosine offset, split sign and magnitude
  logic signed [SumW-1:0] sum;
  logic [SumW-1:0]        sum_abs;
  logic [MW-1:0]          mag1;
  logic [MW-1:0]          n1;
  logic                   sign_q1;
  logic [MW-1:0]          m_q1;
  logic [NW-1:0]          n3_q1;

  assign sum     = $signed({angle_i[ANGLE_WIDTH-1], angle_i})
                 + (req_type_i ? SumW'(psc_pkg::HalfPiQ12) : SumW'(0));
  assign sum_abs = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
  assign mag1    = sum_abs[MW-1:0];
  assign n1      = mag1 + MW'(psc_pkg::PiQ12 - 1);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sign_q1 <= sum[SumW-1];
      m_q1    <= mag1;
      n3_q1   <= n1[MW-1:psc_pkg::TwoPiShift];
    end
  end

  // Stage 2: estimate the turn count by reciprocal multiply
  logic [NW+KW-1:0] prod2;
  logic             sign_q2;
  logic [MW-1:0]    m_q2;
  logic [NW-1:0]    n3_q2;
  logic [KW-1:0]    kest_q2;

  assign prod2 = (NW+KW)'(n3_q1) * (NW+KW)'(Recip);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sign_q2 <= sign_q1;
      m_q2    <= m_q1;
      n3_q2   <= n3_q1;
      kest_q2 <= prod2[NW+KW-1:NW];
    end
  end

  // Stage 3: correct the estimate with one compare
  logic [NW-1:0] kmul3;
  logic [NW-1:0] rem3;
  logic [KW-1:0] k3;
  logic          sign_q3;
  logic [MW-1:0] m_q3;
  logic [KW-1:0] k_q3;

  assign kmul3 = NW'(kest_q2) * NW'(psc_pkg::TwoPiOdd);
  assign rem3  = n3_q2 - kmul3;
  assign k3    = (rem3 >= NW'(psc_pkg::TwoPiOdd)) ? kest_q2 + KW'(1) : kest_q2;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sign_q3 <= sign_q2;
      m_q3    <= m_q2;
      k_q3    <= k3;
    end
  end

  // Stage 4: remove whole turns, restore sign, move to Q14
  logic [MW-1:0]                  red4;
  logic signed [psc_pkg::MagW:0]  mag4;
  logic signed [psc_pkg::MagW:0]  xv4;
  logic signed [psc_pkg::XW-1:0]  x_q;

  assign red4 = m_q3 - MW'(k_q3) * MW'(psc_pkg::TwoPiQ12);
  // The remainder lies in (-pi, pi], so its low bits hold it in two's complement
  assign mag4 = $signed(red4[psc_pkg::MagW:0]);
  assign xv4  = sign_q3 ? -mag4 : mag4;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      x_q <= {xv4, 2'b00};
    end
  end

  assign x_o = x_q;

endmodule

// ===== rtl/psc_parabola.sv =====
// Parabolic approximation, refinement and output saturation, four stages.
`timescale 1ns / 1ps

module psc_parabola #(
  parameter int OUT_FRAC = psc_pkg::OutFracDef
) (
  input  logic                              clk_i,
  input  psc_pkg::par_en_t                  en_i,
  input  logic signed [psc_pkg::XW-1:0]     x_i,
  output logic [psc_pkg::ValueW-1:0]        value_o
);

  localparam int XW  = psc_pkg::XW;
  localparam int T1W = psc_pkg::T1W;
  localparam int SW  = psc_pkg::SW;
  localparam int YW  = psc_pkg::YW;
  localparam int DW  = psc_pkg::DW;
  localparam int RW  = psc_pkg::RW;
  localparam int IF  = psc_pkg::IntFrac;

  localparam logic signed [15:0] CLin = 16'(psc_pkg::KLin);
  localparam logic signed [14:0] CSqr = 15'(psc_pkg::KSqr);
  localparam logic signed [12:0] CFix = 13'(psc_pkg::KFix);

  localparam int Up   = (OUT_FRAC > IF) ? OUT_FRAC - IF : 0;
  localparam int Dn   = (IF > OUT_FRAC) ? IF - OUT_FRAC : 0;
  localparam int SclW = RW + Up + 2;
  localparam logic signed [SclW-1:0] Lim = SclW'(longint'(1) << OUT_FRAC);

  // Stage 5: linear term and x*|x|
  logic signed [XW-1:0]    absx;
  logic signed [XW+15:0]   p_lin;
  logic signed [2*XW-1:0]  p_sq;
  logic signed [T1W-1:0]   t1_q;
  logic signed [SW-1:0]    s_q;

  assign absx  = x_i[XW-1] ? -x_i : x_i;
  assign p_lin = (XW+16)'(x_i) * (XW+16)'(CLin);
  assign p_sq  = (2*XW)'(x_i) * (2*XW)'(absx);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q <= T1W'(p_lin >>> IF);
      s_q  <= SW'(p_sq >>> IF);
    end
  end

  // Stage 6: square term and the parabola y
  logic signed [SW+14:0]  p_t2;
  logic signed [T1W-1:0]  t2;
  logic signed [YW-1:0]   y_q;

  assign p_t2 = (SW+15)'(s_q) * (SW+15)'(CSqr);
  assign t2   = T1W'(p_t2 >>> IF);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      y_q <= YW'(t1_q) - YW'(t2);
    end
  end

  // Stage 7: y*|y| and the refinement difference
  logic signed [YW-1:0]   absy;
  logic signed [2*YW-1:0] p_q;
  logic signed [DW-1:0]   q7;
  logic signed [YW-1:0]   y7_q;
  logic signed [DW-1:0]   d_q;

  assign absy = y_q[YW-1] ? -y_q : y_q;
  assign p_q  = (2*YW)'(y_q) * (2*YW)'(absy);
  assign q7   = DW'(p_q >>> IF);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      y7_q <= y_q;
      d_q  <= q7 - DW'(y_q);
    end
  end

  // Stage 8: apply the correction, rescale and saturate
  logic signed [DW+12:0]  p_fix;
  logic signed [RW-1:0]   r8;
  logic signed [SclW-1:0] scaled;
  logic signed [SclW-1:0] sat;
  logic [psc_pkg::ValueW-1:0] value_q;

  assign p_fix  = (DW+13)'(d_q) * (DW+13)'(CFix);
  assign r8     = RW'(y7_q) + RW'(p_fix >>> IF);
  assign scaled = (SclW'(r8) <<< Up) >>> Dn;

  always_comb begin
    priority if (scaled > Lim) begin
      sat = Lim;
    end else if (scaled < -Lim) begin
      sat = -Lim;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      value_q <= sat[psc_pkg::ValueW-1:0];
    end
  end

  assign value_o = value_q;

endmodule

// ===== rtl/parabolic_sine_cosine.sv =====
// Parabolic sine/cosine top level: handshake control and the two datapath sections.
`timescale 1ns / 1ps
// Approximate sine or cosine of a Q7.12 angle as a Q1.14 value saturated to
// plus or minus one. The block takes one transaction per clock while the
// output is not stalled and returns results in order: four stages reduce the
// angle (offset, reciprocal-multiply turn estimate, one-compare correction,
// turn removal) and four evaluate the parabola and its refinement, one
// multiplier level per stage. Each stage holds a valid bit; a stage loads when
// it is empty or the stage after it moves, so bubbles close up and a stalled
// output holds back only the stages that are full. in_stall_o follows
// out_stall_i combinationally through that chain.

`include "parabolic_sine_cosine_defines.svh"

module parabolic_sine_cosine #(
  parameter int ANGLE_WIDTH = psc_pkg::AngleWidthDef,
  parameter int OUT_FRAC    = psc_pkg::OutFracDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [psc_pkg::ValueW-1:0] value_o
);

  localparam int NS = psc_pkg::NumStages;
  localparam int VW = psc_pkg::ValueW;
  localparam bit OutFracFits = (OUT_FRAC < VW - 1);
  localparam logic signed [VW-1:0] ValueLim = VW'(longint'(1) << OUT_FRAC);

  logic [NS-1:0]      valid_q;
  logic [NS-1:0]      valid_d;
  logic [NS-1:0]      en;
  psc_pkg::stage_en_t stage_en;
  logic signed [psc_pkg::XW-1:0] x;
  logic [VW-1:0]      value;

  // Load a stage when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign valid_d = {valid_q[NS-2:0], in_valid_i};

  // Advance valid bits with their data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (valid_q & ~en) | (valid_d & en);
    end
  end

  assign stage_en.red = en[psc_pkg::RedStages-1:0];
  assign stage_en.par = en[NS-1:psc_pkg::RedStages];

  psc_reduce #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_reduce (
    .clk_i      (clk_i),
    .en_i       (stage_en.red),
    .req_type_i (req_type_i),
    .angle_i    (angle_i),
    .x_o        (x)
  );

  psc_parabola #(
    .OUT_FRAC(OUT_FRAC)
  ) u_parabola (
    .clk_i   (clk_i),
    .en_i    (stage_en.par),
    .x_i     (x),
    .value_o (value)
  );

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NS-1];
  assign value_o     = $signed(value);

  // Input backpressure only ever comes from the output side
  `PSC_ASSERT_ALWAYS(a_stall_from_output, in_stall_o |-> out_stall_i, "input stalled while output free")
  // An empty output stage leaves room for a new transaction
  `PSC_ASSERT_ALWAYS(a_empty_never_stalls, !out_valid_o |-> !in_stall_o, "input stalled with empty output")
  // Delivered values stay within plus or minus one
  `PSC_ASSERT(a_value_range, (out_valid_o && OutFracFits) |-> ($signed(value_o) <= ValueLim && $signed(value_o) >= -ValueLim), "value beyond saturation limit")

endmodule
